FILE: rtl/core/stbw_pkg.sv
// shared constants and codes for the software timer bank with watchdog
package stbw_pkg;

	localparam int NUM_TIMERS_DEF = 8;

	localparam int KIND_W    = 3;
	localparam int IDX_PORT_W = 4;
	localparam int SECS_W    = 32;
	localparam int RKIND_W   = 2;
	localparam int PERIOD_W  = 16;
	localparam int TICKS_W   = 31;
	localparam int DVD_W     = SECS_W + 1;
	localparam int DIV_CNT_W = 6;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2;
	localparam logic [PERIOD_W-1:0] WD_MAX       = 16'hFFFF;
	localparam logic [TICKS_W-1:0]  TICK_LIMIT   = 31'h4000_0000;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_START  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STOP   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WD_SET = 3'd4;

	// result kinds
	localparam logic [RKIND_W-1:0] RES_ACK     = 2'd0;
	localparam logic [RKIND_W-1:0] RES_QUERY   = 2'd1;
	localparam logic [RKIND_W-1:0] RES_EXPIRED = 2'd2;
	localparam logic [RKIND_W-1:0] RES_SYS_RST = 2'd3;

	typedef struct packed {
		logic [RKIND_W-1:0]    kind;
		logic [IDX_PORT_W-1:0] idx;
		logic                  run;
	} pend_res_t;

endpackage

FILE: rtl/core/stbw_ram.sv
// generic single-port-write, registered-read ram
module stbw_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/software_timer_bank_with_watchdog.sv
// top level: one-shot timer bank counted in slow ticks plus a software watchdog
//
// usage: a request is taken at a rising edge with start high and busy low; kind selects
// start, stop, query, tick or watchdog set. busy stays high until the request's last
// result has been placed on the result ports.
// results come one per cycle on result_valid, each held for exactly one cycle; last marks
// the final result of a request. the receiver cannot stall, so results are never held.
// request flow, with N = NUM_TIMERS:
//   stop, query, watchdog set, unknown kinds: straight from idle to the result stage
//   start: a one-bit-per-cycle restoring divide over 33 bits, then the ram write, then
//   the result; a start with an out-of-range index goes straight to the result stage
//   tick: walks the timers through the counter ram (read, then modify and write back
//   each entry), then the watchdog step, then one result per cycle, up to N + 1 results
// tick counts live in a registered-read ram; active flags sit in flip-flops.
// tick_period is written through tick_period_we/tick_period_wdata at any edge; it must
// only change while the block is idle. reset clears all timers, stops the watchdog and
// loads a tick period of 2 seconds. counter ram contents are undefined after reset and
// are only used for timers that were started.
module software_timer_bank_with_watchdog #(
	parameter int NUM_TIMERS = stbw_pkg::NUM_TIMERS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_period_we,
	input  logic [stbw_pkg::PERIOD_W-1:0]     tick_period_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [stbw_pkg::KIND_W-1:0]       kind,
	input  logic [stbw_pkg::IDX_PORT_W-1:0]   timer_index,
	input  logic [stbw_pkg::SECS_W-1:0]       seconds,
	output logic                              result_valid,
	output logic [stbw_pkg::RKIND_W-1:0]      result_kind,
	output logic [stbw_pkg::IDX_PORT_W-1:0]   timer_index_out,
	output logic                              running,
	output logic                              slow_tick_enable,
	output logic                              last
);

	import stbw_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_TRD   = 3'd3;
	localparam logic [2:0] ST_TPROC = 3'd4;
	localparam logic [2:0] ST_WD    = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]            state_q;
	logic [PERIOD_W-1:0]   tick_period_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic [NUM_TIMERS-1:0] exp_mask_q;
	logic                  wd_run_q;
	logic [PERIOD_W-1:0]   wd_left_q;
	logic                  wd_req_q;
	pend_res_t             pend_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      tgt_idx_q;
	logic [DIV_CNT_W-1:0]  bit_cnt_q;
	logic [DVD_W-1:0]      dvd_q;
	logic [PERIOD_W-1:0]   rem_q;
	logic [DVD_W-1:0]      quo_q;

	logic                  result_valid_q;
	logic [RKIND_W-1:0]    result_kind_q;
	logic [IDX_PORT_W-1:0] timer_index_out_q;
	logic                  running_q;
	logic                  slow_tick_enable_q;
	logic                  last_q;

	logic                  accept;
	logic                  in_range;
	logic [IDX_W-1:0]      idx_lo;
	logic [PERIOD_W-1:0]   period_nz;
	logic [DVD_W-1:0]      secs_nz;
	logic [DVD_W-1:0]      dvd_init;
	logic [PERIOD_W:0]     rem_sh;
	logic                  div_ge;
	logic [PERIOD_W-1:0]   rem_sub;
	logic [TICKS_W-1:0]    ticks_sat;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [TICKS_W-1:0]    ram_wdata;
	logic                  ram_re;
	logic [TICKS_W-1:0]    ram_rdata;
	logic [TICKS_W-1:0]    ticks_dec;

	logic [IDX_W-1:0]      exp_sel;
	logic [NUM_TIMERS-1:0] exp_mask_nxt;
	logic                  tick_en;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign in_range  = ({1'b0, timer_index} < (IDX_PORT_W + 1)'(NUM_TIMERS));
	assign idx_lo    = timer_index[IDX_W-1:0];
	assign period_nz = (tick_period_q == '0) ? PERIOD_W'(1) : tick_period_q;
	assign secs_nz   = (seconds == '0) ? DVD_W'(1) : {1'b0, seconds};
	assign dvd_init  = secs_nz + DVD_W'(period_nz) - DVD_W'(1);

	// restoring divide step, one quotient bit per cycle
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign div_ge  = (rem_sh >= {1'b0, period_nz});
	// difference is below the period whenever it is taken
	assign rem_sub = rem_sh[PERIOD_W-1:0] - period_nz;
	assign ticks_sat = (quo_q > DVD_W'(TICK_LIMIT)) ? TICK_LIMIT : quo_q[TICKS_W-1:0];

	assign ticks_dec = (ram_rdata == '0) ? '0 : ram_rdata - TICKS_W'(1);

	assign ram_re    = (state_q == ST_TRD);
	assign ram_we    = (state_q == ST_WRITE) || ((state_q == ST_TPROC) && active_q[cnt_q]);
	assign ram_waddr = (state_q == ST_WRITE) ? tgt_idx_q : cnt_q;
	assign ram_wdata = (state_q == ST_WRITE) ? ticks_sat : ticks_dec;

	stbw_ram #(
		.WIDTH (TICKS_W),
		.DEPTH (NUM_TIMERS)
	) u_ticks_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	// lowest pending expiry goes out first
	always_comb begin
		exp_sel = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (exp_mask_q[i]) begin
				exp_sel = IDX_W'(i);
			end
		end
		exp_mask_nxt = exp_mask_q & ~(NUM_TIMERS'(1) << exp_sel);
	end

	assign tick_en = (|active_q) || wd_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tick_period_q  <= PERIOD_RESET;
			active_q       <= '0;
			exp_mask_q     <= '0;
			wd_run_q       <= 1'b0;
			wd_left_q      <= '0;
			wd_req_q       <= 1'b0;
			cnt_q          <= '0;
			bit_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (tick_period_we) begin
				tick_period_q <= tick_period_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						exp_mask_q <= '0;
						wd_req_q   <= 1'b0;
						case (kind)
							KIND_START: begin
								bit_cnt_q <= '0;
								state_q   <= in_range ? ST_DIV : ST_EMIT;
							end
							KIND_STOP: begin
								if (in_range) begin
									active_q[idx_lo] <= 1'b0;
								end
								state_q <= ST_EMIT;
							end
							KIND_TICK: begin
								cnt_q   <= '0;
								state_q <= ST_TRD;
							end
							KIND_WD_SET: begin
								if (seconds == '0) begin
									wd_run_q <= 1'b0;
								end else begin
									wd_run_q  <= 1'b1;
									wd_left_q <= (seconds > SECS_W'(WD_MAX)) ? WD_MAX
										: seconds[PERIOD_W-1:0];
								end
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_DIV: begin
					bit_cnt_q <= bit_cnt_q + DIV_CNT_W'(1);
					if (bit_cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					active_q[tgt_idx_q] <= 1'b1;
					state_q             <= ST_EMIT;
				end
				ST_TRD: begin
					state_q <= ST_TPROC;
				end
				ST_TPROC: begin
					if (active_q[cnt_q] && (ticks_dec == '0)) begin
						active_q[cnt_q]   <= 1'b0;
						exp_mask_q[cnt_q] <= 1'b1;
					end
					if (cnt_q == IDX_W'(NUM_TIMERS - 1)) begin
						state_q <= ST_WD;
					end else begin
						cnt_q   <= cnt_q + IDX_W'(1);
						state_q <= ST_TRD;
					end
				end
				ST_WD: begin
					if (wd_run_q) begin
						if (wd_left_q > period_nz) begin
							wd_left_q <= wd_left_q - period_nz;
						end else begin
							wd_run_q <= 1'b0;
							wd_req_q <= 1'b1;
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					result_valid_q <= 1'b1;
					if (|exp_mask_q) begin
						exp_mask_q <= exp_mask_nxt;
						if ((exp_mask_nxt == '0) && !wd_req_q) begin
							state_q <= ST_IDLE;
						end
					end else begin
						wd_req_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_idx_q <= idx_lo;
			dvd_q     <= dvd_init;
			rem_q     <= '0;
			quo_q     <= '0;
			case (kind)
				KIND_START, KIND_STOP: begin
					pend_q <= '{kind: RES_ACK, idx: timer_index, run: 1'b0};
				end
				KIND_QUERY: begin
					pend_q <= '{kind: RES_QUERY, idx: timer_index,
						run: in_range && active_q[idx_lo]};
				end
				default: begin
					pend_q <= '{kind: RES_ACK, idx: '0, run: 1'b0};
				end
			endcase
		end
		if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= div_ge ? rem_sub : rem_sh[PERIOD_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], div_ge};
		end
		if (state_q == ST_EMIT) begin
			slow_tick_enable_q <= tick_en;
			running_q          <= 1'b0;
			if (|exp_mask_q) begin
				result_kind_q     <= RES_EXPIRED;
				timer_index_out_q <= IDX_PORT_W'(exp_sel);
				last_q            <= (exp_mask_nxt == '0) && !wd_req_q;
			end else if (wd_req_q) begin
				result_kind_q     <= RES_SYS_RST;
				timer_index_out_q <= '0;
				last_q            <= 1'b1;
			end else begin
				result_kind_q     <= pend_q.kind;
				timer_index_out_q <= pend_q.idx;
				running_q         <= pend_q.run;
				last_q            <= 1'b1;
			end
		end
	end

	assign result_valid     = result_valid_q;
	assign result_kind      = result_kind_q;
	assign timer_index_out  = timer_index_out_q;
	assign running          = running_q;
	assign slow_tick_enable = slow_tick_enable_q;
	assign last             = last_q;

	// results of one request come out back to back
	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid)
		else $error("result stream of a request has a gap");

	// once idle, the result on the port must have been the final one
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !busy |-> last)
		else $error("block went idle before the last result");

	a_expired_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == RES_EXPIRED)
		|-> ({1'b0, timer_index_out} < (IDX_PORT_W + 1)'(NUM_TIMERS)))
		else $error("expiry reported for a timer that does not exist");

	a_running_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && running |-> (result_kind == RES_QUERY))
		else $error("running flag set outside a query answer");

	// the watchdog reset request stops the watchdog
	a_sys_rst_stops_wd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == RES_SYS_RST) |-> !wd_run_q)
		else $error("watchdog still running after its reset request");

endmodule

FILE: tb/software_timer_bank_with_watchdog_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the software timer bank with watchdog
module software_timer_bank_with_watchdog_tb;
	import stbw_pkg::*;

	localparam int NT = NUM_TIMERS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int PER_PHASE = 16;
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_WD_SET + 1'b1;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;

	typedef struct {
		logic [KIND_W-1:0]     kind;
		logic [IDX_PORT_W-1:0] idx;
		logic [SECS_W-1:0]     secs;
		bit                    drain;
	} request_t;

	typedef struct {
		logic [RKIND_W-1:0]    rkind;
		logic [IDX_PORT_W-1:0] idx;
		logic                  run;
		logic                  ste;
		logic                  last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_period_we = 1'b0;
	logic [PERIOD_W-1:0] tick_period_wdata = PERIOD_RESET;
	logic start = 1'b0;
	logic busy;
	logic [KIND_W-1:0] kind = '0;
	logic [IDX_PORT_W-1:0] timer_index = '0;
	logic [SECS_W-1:0] seconds = '0;
	logic result_valid;
	logic [RKIND_W-1:0] result_kind;
	logic [IDX_PORT_W-1:0] timer_index_out;
	logic running;
	logic slow_tick_enable;
	logic last;

	// timer bank mirror
	logic [PERIOD_W-1:0] cur_period = PERIOD_RESET;
	bit [NT-1:0] timer_on = '0;
	logic [TICKS_W-1:0] ticks_left [NT];
	bit wd_on = 1'b0;
	logic [PERIOD_W-1:0] wd_left = '0;

	request_t request_q[$];
	result_t pending_results[$];
	int n_sent = 0;
	int n_taken = 0;
	int mismatches = 0;
	int quiet = 0;
	int gap_left = 0;
	int burst_left = 1;
	bit req_taken = 1'b0;

	software_timer_bank_with_watchdog DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick_period_we(tick_period_we),
		.tick_period_wdata(tick_period_wdata),
		.start(start),
		.busy(busy),
		.kind(kind),
		.timer_index(timer_index),
		.seconds(seconds),
		.result_valid(result_valid),
		.result_kind(result_kind),
		.timer_index_out(timer_index_out),
		.running(running),
		.slow_tick_enable(slow_tick_enable),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// work out the results of one accepted request and update the mirror
	task automatic apply_request(input logic [KIND_W-1:0] k, input logic [IDX_PORT_W-1:0] idx,
			input logic [SECS_W-1:0] secs);
		result_t outs[$];
		result_t r;
		logic [PERIOD_W-1:0] pe;
		longint unsigned span;
		longint unsigned cnt;
		logic ste;
		pe = (cur_period == '0) ? 16'd1 : cur_period;
		r = '{default: '0};
		case (k)
			KIND_START: begin
				if (idx < NT) begin
					span = (secs == '0) ? 1 : secs;
					cnt = (span + pe - 1) / pe;
					if (cnt > TICK_LIMIT)
						cnt = TICK_LIMIT;
					ticks_left[idx] = cnt[TICKS_W-1:0];
					timer_on[idx] = 1'b1;
				end
				r.rkind = RES_ACK;
				r.idx = idx;
				outs.push_back(r);
			end
			KIND_STOP: begin
				if (idx < NT)
					timer_on[idx] = 1'b0;
				r.rkind = RES_ACK;
				r.idx = idx;
				outs.push_back(r);
			end
			KIND_QUERY: begin
				r.rkind = RES_QUERY;
				r.idx = idx;
				r.run = (idx < NT) && timer_on[idx];
				outs.push_back(r);
			end
			KIND_TICK: begin
				for (int t = 0; t < NT; t++) begin
					if (timer_on[t]) begin
						if (ticks_left[t] != '0)
							ticks_left[t]--;
						if (ticks_left[t] == '0) begin
							timer_on[t] = 1'b0;
							r.rkind = RES_EXPIRED;
							r.idx = 4'(t);
							outs.push_back(r);
						end
					end
				end
				if (wd_on) begin
					if (wd_left > pe) begin
						wd_left -= pe;
					end else begin
						wd_on = 1'b0;
						r.rkind = RES_SYS_RST;
						r.idx = '0;
						outs.push_back(r);
					end
				end
				if (outs.size() == 0) begin
					r.rkind = RES_ACK;
					r.idx = '0;
					outs.push_back(r);
				end
			end
			KIND_WD_SET: begin
				if (secs == '0) begin
					wd_on = 1'b0;
				end else begin
					wd_left = (secs > WD_MAX) ? WD_MAX : secs[PERIOD_W-1:0];
					wd_on = 1'b1;
				end
				r.rkind = RES_ACK;
				outs.push_back(r);
			end
			default: begin
				r.rkind = RES_ACK;
				outs.push_back(r);
			end
		endcase
		ste = wd_on || (|timer_on);
		foreach (outs[i]) begin
			outs[i].ste = ste;
			outs[i].last = (i == outs.size() - 1);
			pending_results.push_back(outs[i]);
		end
	endtask

	task automatic send(input logic [KIND_W-1:0] k, input logic [IDX_PORT_W-1:0] idx,
			input logic [SECS_W-1:0] secs, input bit drain);
		request_t q;
		q.kind = k;
		q.idx = idx;
		q.secs = secs;
		q.drain = drain;
		request_q.push_back(q);
		n_sent++;
	endtask

	function automatic logic [SECS_W-1:0] pick_duration(input int pe);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return $urandom;
		if (r < 18)
			return 32'h4000_0000;
		if (r < 20)
			return 32'h4000_0001;
		return $urandom_range(1, 3 * pe);
	endfunction

	function automatic logic [SECS_W-1:0] pick_wd_value(input int pe);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return $urandom;
		return $urandom_range(1, 4 * pe);
	endfunction

	task automatic add_random(input int count);
		int goal;
		int pe;
		int r;
		int arm;
		goal = n_sent + count;
		pe = (cur_period == '0) ? 1 : int'(cur_period);
		while (n_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				// arm a few timers with short durations, then tick them down
				arm = $urandom_range(1, 4);
				repeat (arm)
					send(KIND_START, 4'($urandom_range(0, NT - 1)), $urandom_range(0, 2 * pe),
						$urandom_range(0, 19) == 0);
				repeat ($urandom_range(1, 4))
					send(KIND_TICK, 4'($urandom), $urandom, $urandom_range(0, 19) == 0);
			end else if (r < 48) begin
				send(KIND_TICK, 4'($urandom), $urandom, $urandom_range(0, 19) == 0);
			end else if (r < 62) begin
				send(KIND_START,
					4'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, NT - 1)),
					pick_duration(pe), $urandom_range(0, 19) == 0);
			end else if (r < 71) begin
				send(KIND_STOP, 4'($urandom), $urandom, $urandom_range(0, 19) == 0);
			end else if (r < 82) begin
				send(KIND_QUERY, 4'($urandom), $urandom, $urandom_range(0, 19) == 0);
			end else if (r < 94) begin
				send(KIND_WD_SET, 4'($urandom), pick_wd_value(pe), $urandom_range(0, 19) == 0);
			end else begin
				send(KIND_W'($urandom_range(int'(KIND_SPARE_LO), int'(KIND_SPARE_HI))),
					4'($urandom), $urandom, 1'b0);
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (!(n_taken == n_sent && pending_results.size() == 0 && !busy));
	endtask

	task automatic set_period(input logic [PERIOD_W-1:0] p);
		@(negedge clk);
		tick_period_we <= 1'b1;
		tick_period_wdata <= p;
		cur_period = p;
		@(negedge clk);
		tick_period_we <= 1'b0;
	endtask

	// request driver: bursts of requests with random gaps
	always @(negedge clk) begin : drv
		request_t nxt;
		bit launch;
		launch = 1'b0;
		if (arst_n && !(start && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (request_q.size() > 0 &&
					!(request_q[0].drain && (pending_results.size() != 0 || busy))) begin
				nxt = request_q.pop_front();
				launch = 1'b1;
				kind <= nxt.kind;
				timer_index <= nxt.idx;
				seconds <= nxt.secs;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 9))
						0, 1, 2: gap_left = 0;
						3: gap_left = $urandom_range(10, 40);
						default: gap_left = $urandom_range(1, 6);
					endcase
				end
			end
			start <= launch;
		end
		req_taken = 1'b0;
	end

	// result checker, request capture and stall watchdog
	always @(posedge clk) begin : mon
		result_t want;
		bit took;
		took = start && !busy;
		if (arst_n) begin
			if (result_valid) begin
				if (pending_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d index %0d",
						result_kind, timer_index_out));
				end else begin
					want = pending_results.pop_front();
					if (result_kind !== want.rkind)
						flag_mismatch($sformatf("result_kind got %0d expected %0d",
							result_kind, want.rkind));
					if (timer_index_out !== want.idx)
						flag_mismatch($sformatf("timer_index_out got %0d expected %0d",
							timer_index_out, want.idx));
					if (running !== want.run)
						flag_mismatch($sformatf("running got %b expected %b", running, want.run));
					if (slow_tick_enable !== want.ste)
						flag_mismatch($sformatf("slow_tick_enable got %b expected %b",
							slow_tick_enable, want.ste));
					if (last !== want.last)
						flag_mismatch($sformatf("last got %b expected %b", last, want.last));
				end
			end
			if (took) begin
				apply_request(kind, timer_index, seconds);
				n_taken++;
				req_taken = 1'b1;
			end
			if (result_valid || took)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("software_timer_bank_with_watchdog_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed part at the reset tick period of two seconds
		send(KIND_TICK, '0, '0, 1'b0);
		send(KIND_START, 4'd0, 32'd0, 1'b0);
		send(KIND_START, 4'd1, 32'd3, 1'b0);
		send(KIND_START, 4'd8, 32'd5, 1'b0);
		send(KIND_QUERY, 4'd15, '0, 1'b0);
		send(KIND_STOP, 4'd15, '0, 1'b0);
		send(KIND_WD_SET, '0, 32'd3, 1'b0);
		send(KIND_TICK, 4'hF, 32'hFFFF_FFFF, 1'b0);
		send(KIND_START, 4'd1, 32'd5, 1'b0);
		send(KIND_QUERY, 4'd1, '0, 1'b0);
		send(KIND_TICK, '0, '0, 1'b0);
		send(KIND_WD_SET, '0, 32'h0001_0000, 1'b0);
		send(KIND_WD_SET, '0, 32'd0, 1'b0);
		send(KIND_START, 4'd2, 32'hFFFF_FFFF, 1'b0);
		send(KIND_STOP, 4'd2, '0, 1'b0);
		send(KIND_QUERY, 4'd2, '0, 1'b0);
		send(KIND_SPARE_LO, 4'd3, 32'd7, 1'b0);
		send(KIND_SPARE_HI, 4'hF, 32'hFFFF_FFFF, 1'b0);
		// every timer and the watchdog run out on the same tick
		for (int t = 0; t < NT; t++)
			send(KIND_START, 4'(t), 32'd1, 1'b0);
		send(KIND_WD_SET, '0, 32'd1, 1'b0);
		send(KIND_TICK, '0, '0, 1'b1);
		add_random(PER_PHASE);
		wait_idle();

		set_period(16'd1);
		@(posedge clk);
		add_random(PER_PHASE);
		wait_idle();
		set_period(16'd3);
		@(posedge clk);
		add_random(PER_PHASE);
		wait_idle();
		set_period(16'hFFFF);
		@(posedge clk);
		add_random(PER_PHASE);
		wait_idle();
		set_period(16'd0);
		@(posedge clk);
		add_random(PER_PHASE);
		wait_idle();
		set_period(16'($urandom_range(4, 65534)));
		@(posedge clk);
		add_random(PER_PHASE);
		wait_idle();

		repeat (60) @(negedge clk);
		if (mismatches == 0)
			$display("software_timer_bank_with_watchdog_tb OK");
		else
			$display("software_timer_bank_with_watchdog_tb NOT OK");
		$finish;
	end

endmodule
